/* hdl/csq_pkg.sv */
`default_nettype none
package csq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int COUNT_W         = 16;
	localparam int TID_W           = 8;
	localparam int FUNC_W          = 2;
	localparam int STATUS_W        = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [FUNC_W-1:0] {
		FN_DOWN = 2'd0,
		FN_UP   = 2'd1,
		FN_TRY  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_QUEUED  = 3'd1,
		ST_REFUSED = 3'd2,
		ST_FULL    = 3'd3,
		ST_POSTED  = 3'd4
	} status_t;

	// queue requests from the control logic
	typedef struct packed {
		logic             flush;
		logic             push;
		logic             pop;
		logic [TID_W-1:0] tid;
	} q_ctrl_t;

	// queue condition seen by the control logic
	typedef struct packed {
		logic             empty;
		logic             full;
		logic [TID_W-1:0] head_tid;
	} q_stat_t;

endpackage
`default_nettype wire

/* hdl/csq_cell.sv */
`default_nettype none
module csq_cell (
	input  wire                        clk,
	input  wire                        shift_en,
	input  wire                        load_en,
	input  wire  [csq_pkg::TID_W-1:0]  load_data,
	input  wire  [csq_pkg::TID_W-1:0]  next_data,
	output logic [csq_pkg::TID_W-1:0]  data
);
	import csq_pkg::*;

	logic [TID_W-1:0] data_q;

	// pop moves every entry one cell toward the head; push lands in the first free cell
	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= next_data;
		end else if (load_en) begin
			data_q <= load_data;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

/* hdl/csq_chain.sv */
`default_nettype none
module csq_chain #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  csq_pkg::q_ctrl_t  ctrl,
	output csq_pkg::q_stat_t  stat
);
	import csq_pkg::*;

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic [OCC_W-1:0] occ_q;
	logic [TID_W-1:0] cell_data [QUEUE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.flush) begin
			occ_q <= '0;
		end else if (ctrl.push) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (ctrl.pop) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TID_W-1:0] nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		csq_cell u_cell (
			.clk       (clk),
			.shift_en  (ctrl.pop),
			.load_en   (ctrl.push && (occ_q == OCC_W'(i))),
			.load_data (ctrl.tid),
			.next_data (nxt),
			.data      (cell_data[i])
		);
	end

	assign stat.empty    = (occ_q == '0);
	assign stat.full     = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign stat.head_tid = cell_data[0];

endmodule
`default_nettype wire

/* hdl/counting_semaphore_wait_queue_unit.sv */
`default_nettype none
// Counting semaphore with a FIFO of waiting thread IDs. Each input transaction
// (func: 0 down, 1 up, 2 trywait) yields exactly one result transaction, registered
// in the cycle after acceptance; one transaction per cycle is sustained, and in_stall
// rises only while a finished result is held by out_stall. The count is one 16-bit
// register; the wait queue is a row of QUEUE_DEPTH cells that shift toward the
// head on every pop, so the oldest waiter always sits in cell 0 and a push drops
// into the cell indexed by the occupancy. Writing cfg_wr_data with cfg_wr_en
// loads the count and empties the queue; write only while idle.
// Status codes: 0 granted, 1 queued, 2 refused, 3 queue full, 4 posted.
module counting_semaphore_wait_queue_unit #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration
	input  wire                            cfg_wr_en,
	input  wire  [csq_pkg::COUNT_W-1:0]    cfg_wr_data,
	// request channel
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [csq_pkg::FUNC_W-1:0]     func,
	input  wire  [csq_pkg::TID_W-1:0]      thread_id,
	// result channel
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [csq_pkg::STATUS_W-1:0]   status,
	output logic                           wake_valid,
	output logic [csq_pkg::TID_W-1:0]      wake_thread,
	output logic [csq_pkg::COUNT_W-1:0]    count_after
);
	import csq_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	status_t            status_q;
	logic               wake_valid_q;
	logic [TID_W-1:0]   wake_thread_q;
	logic [COUNT_W-1:0] count_after_q;

	q_ctrl_t q_ctrl;
	q_stat_t q_stat;

	logic               accept;
	logic [COUNT_W-1:0] count_nxt;
	status_t            status_nxt;
	logic               wake_nxt;
	logic               push_nxt;
	logic               pop_nxt;

	// a held result blocks new requests; taking it frees the slot in the same cycle
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// next count, status and queue action for the request on the inputs
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_REFUSED;
		wake_nxt   = 1'b0;
		push_nxt   = 1'b0;
		pop_nxt    = 1'b0;
		case (func_t'(func))
			FN_DOWN: begin
				if (count_q != '0) begin
					count_nxt  = count_q - COUNT_W'(1);
					status_nxt = ST_GRANTED;
				end else if (q_stat.full) begin
					status_nxt = ST_FULL;
				end else begin
					push_nxt   = 1'b1;
					status_nxt = ST_QUEUED;
				end
			end
			FN_UP: begin
				// saturate at the top of the range; a waiter is still released
				if (count_q != COUNT_MAX) begin
					count_nxt = count_q + COUNT_W'(1);
				end
				if (!q_stat.empty) begin
					pop_nxt  = 1'b1;
					wake_nxt = 1'b1;
				end
				status_nxt = ST_POSTED;
			end
			FN_TRY: begin
				if (count_q != '0) begin
					count_nxt  = count_q - COUNT_W'(1);
					status_nxt = ST_GRANTED;
				end
			end
			default: begin
				// unused code: refused, nothing changes
				status_nxt = ST_REFUSED;
			end
		endcase
	end

	assign q_ctrl.flush = cfg_wr_en;
	assign q_ctrl.push  = accept && push_nxt && !cfg_wr_en;
	assign q_ctrl.pop   = accept && pop_nxt && !cfg_wr_en;
	assign q_ctrl.tid   = thread_id;

	csq_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat)
	);

	// semaphore count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// result register, control part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, payload; wake_thread reads zero when nobody is woken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nxt;
			wake_valid_q  <= wake_nxt;
			wake_thread_q <= wake_nxt ? q_stat.head_tid : '0;
			count_after_q <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign wake_valid  = wake_valid_q;
	assign wake_thread = wake_thread_q;
	assign count_after = count_after_q;

	// a woken waiter only comes with a post
	a_wake_on_post: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wake_valid) |-> (status == ST_POSTED))
		else $error("wake reported without a post");

	// a request only queues when no unit was left
	a_queue_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_QUEUED) |-> (count_after == '0))
		else $error("queued while count nonzero");

	// register write leaves an empty queue
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> q_stat.empty)
		else $error("queue not empty after count load");

	// every accepted request gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request produced no result");

endmodule
`default_nettype wire

/* sim/counting_semaphore_wait_queue_checker.sv */
`timescale 1ns / 1ps
module counting_semaphore_wait_queue_checker #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire  [csq_pkg::COUNT_W-1:0]    cfg_wr_data,
	input  wire                            in_valid,
	input  wire                            in_stall,
	input  wire  [csq_pkg::FUNC_W-1:0]     func,
	input  wire  [csq_pkg::TID_W-1:0]      thread_id,
	input  wire                            out_valid,
	input  wire                            out_stall,
	input  wire  [csq_pkg::STATUS_W-1:0]   status,
	input  wire                            wake_valid,
	input  wire  [csq_pkg::TID_W-1:0]      wake_thread,
	input  wire  [csq_pkg::COUNT_W-1:0]    count_after,
	output int                             mismatch_count,
	output int                             results_outstanding
);
	import csq_pkg::*;

	typedef struct packed {
		status_t            st;
		logic               woke;
		logic [TID_W-1:0]   woken_tid;
		logic [COUNT_W-1:0] cnt;
	} sem_result_t;

	// shadow of the semaphore
	logic [COUNT_W-1:0] sem_count;
	logic [TID_W-1:0]   waiters [QUEUE_DEPTH];
	int unsigned        wq_head, wq_tail, wq_fill;

	sem_result_t awaited_results[$];
	sem_result_t want;
	int          errors;

	function automatic sem_result_t predict_semaphore_op(input logic [FUNC_W-1:0] op,
			input logic [TID_W-1:0] tid);
		sem_result_t r;
		r = '{st: ST_REFUSED, woke: 1'b0, woken_tid: '0, cnt: '0};
		case (op)
			FN_DOWN: begin
				if (sem_count != 0) begin
					sem_count = sem_count - 1'b1;
					r.st = ST_GRANTED;
				end else if (wq_fill >= QUEUE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					waiters[wq_tail] = tid;
					wq_tail = (wq_tail + 1 == QUEUE_DEPTH) ? 0 : wq_tail + 1;
					wq_fill++;
					r.st = ST_QUEUED;
				end
			end
			FN_UP: begin
				if (sem_count != COUNT_MAX)
					sem_count = sem_count + 1'b1;
				if (wq_fill != 0) begin
					r.woke = 1'b1;
					r.woken_tid = waiters[wq_head];
					wq_head = (wq_head + 1 == QUEUE_DEPTH) ? 0 : wq_head + 1;
					wq_fill--;
				end
				r.st = ST_POSTED;
			end
			FN_TRY: begin
				if (sem_count != 0) begin
					sem_count = sem_count - 1'b1;
					r.st = ST_GRANTED;
				end
			end
			default: r.st = ST_REFUSED;
		endcase
		r.cnt = sem_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sem_count = '0;
			wq_head = 0;
			wq_tail = 0;
			wq_fill = 0;
			errors = 0;
			awaited_results.delete();
			mismatch_count <= 0;
			results_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result transaction with none awaited: status %0d count %0d",
						status, count_after);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (wake_valid !== want.woke) begin
						$error("wake_valid: expected %0d, got %0d", want.woke, wake_valid);
						errors++;
					end
					if (wake_thread !== want.woken_tid) begin
						$error("wake_thread: expected %0d, got %0d", want.woken_tid,
							wake_thread);
						errors++;
					end
					if (count_after !== want.cnt) begin
						$error("count_after: expected %0d, got %0d", want.cnt, count_after);
						errors++;
					end
				end
			end
			// reload flushes the wait queue
			if (cfg_wr_en) begin
				sem_count = cfg_wr_data;
				wq_head = 0;
				wq_tail = 0;
				wq_fill = 0;
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_semaphore_op(func, thread_id));
			mismatch_count <= errors;
			results_outstanding <= awaited_results.size();
		end
	end

endmodule

/* sim/counting_semaphore_wait_queue_unit_test.sv */
`timescale 1ns / 1ps
module counting_semaphore_wait_queue_unit_test;
	import csq_pkg::*;

	// func code the block does not define; must come back refused
	localparam logic [FUNC_W-1:0] FN_UNDEFINED = 2'd3;
	// cycles with no transaction on any port before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// the result is registered; give a little margin after draining
	localparam int DRAIN_CYCLES = 4;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0]  cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func = '0;
	logic [TID_W-1:0]    thread_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                wake_valid;
	logic [TID_W-1:0]    wake_thread;
	logic [COUNT_W-1:0]  count_after;

	int mismatch_count;
	int results_outstanding;

	// idle odds, percent per cycle, for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	counting_semaphore_wait_queue_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.thread_id   (thread_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.wake_valid  (wake_valid),
		.wake_thread (wake_thread),
		.count_after (count_after)
	);

	// predicts each accepted request and scores every result transaction
	counting_semaphore_wait_queue_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.func                (func),
		.thread_id           (thread_id),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.wake_valid          (wake_valid),
		.wake_thread         (wake_thread),
		.count_after         (count_after),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// hang detector: any transaction or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request and hold it until the block takes it. Random idle
	// cycles go in front, so gaps land anywhere relative to the block's work.
	task automatic issue(input logic [FUNC_W-1:0] op, input logic [TID_W-1:0] tid);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		thread_id <= tid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every awaited result has been taken.
	// The first edge lets the checker count a transaction accepted just now.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reload the count (and flush waiters); only done with the block idle.
	task automatic load_count(input logic [COUNT_W-1:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One random stretch: fresh starting count, then a request mix biased
	// toward a chosen behavior. Low starting counts dominate so that the wait
	// queue fills, wraps and overflows; some stretches start near the top
	// to exercise saturation.
	task automatic run_stretch(input int n_req);
		int pick;
		int roll;
		int w_down;
		int w_up;
		int w_try;
		logic [COUNT_W-1:0] start;
		logic [FUNC_W-1:0] op;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			start = COUNT_W'($urandom_range(0, 3));
		else if (pick < 7)
			start = COUNT_W'($urandom_range(0, 65535));
		else if (pick == 7)
			start = COUNT_MAX;
		else if (pick == 8)
			start = COUNT_MAX - COUNT_W'($urandom_range(0, 3));
		else
			start = '0;
		load_count(start);
		case ($urandom_range(0, 3))
			0: begin w_down = 40; w_up = 30; w_try = 26; end
			1: begin w_down = 65; w_up = 20; w_try = 12; end // drives queue to full
			2: begin w_down = 20; w_up = 60; w_try = 17; end // drains, climbs count
			default: begin w_down = 30; w_up = 20; w_try = 47; end
		endcase
		repeat (n_req) begin
			roll = $urandom_range(0, 99);
			if (roll < w_down)
				op = FN_DOWN;
			else if (roll < w_down + w_up)
				op = FN_UP;
			else if (roll < w_down + w_up + w_try)
				op = FN_TRY;
			else
				op = FN_UNDEFINED;
			issue(op, TID_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		load_count('0);
		issue(FN_TRY, 8'hFF);           // nothing available: refused
		issue(FN_UNDEFINED, 8'hFF);     // undefined op: refused, no state change
		// sixteen downs on an empty semaphore fill the queue; one thread
		// shows up twice in a row
		for (int i = 0; i < 16; i++) begin
			if (i == 0)
				issue(FN_DOWN, 8'h00);
			else if (i == 15)
				issue(FN_DOWN, 8'hFF);
			else if (i == 7 || i == 8)
				issue(FN_DOWN, 8'h5A);
			else
				issue(FN_DOWN, 8'(i * 17));
		end
		issue(FN_DOWN, 8'hC3);          // queue full
		issue(FN_UP, 8'h00);            // wakes the oldest waiter
		issue(FN_UP, 8'hFF);
		// saturation at the top of the count
		load_count(COUNT_MAX - 1'b1);
		issue(FN_UP, 8'h81);
		issue(FN_UP, 8'h7E);            // already at max: stays there
		issue(FN_TRY, 8'h3C);
		load_count(COUNT_MAX);
		issue(FN_DOWN, 8'hA5);

		// --- random, three back-pressure regimes ---
		for (int phase = 0; phase < 3; phase++) begin
			settle();   // sender holds off until everything is back
			case (phase)
				0: begin send_idle_pct = 21; recv_idle_pct = 81; end
				1: begin send_idle_pct = 81; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (7) run_stretch($urandom_range(40, 80));
		end

		settle();
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
